FILE: rtl/aesd_pkg.sv
// package: shared types, constants and GF/S-box functions for the AES-128 decryptor
package aesd_pkg;

   localparam int unsigned KeyWordW = 64;
   localparam int unsigned StoreDepth = 22;
   localparam int unsigned StoreAddrW = 5;
   localparam int unsigned NumRounds = 10;
   localparam int unsigned RoundW = 4;
   localparam int unsigned CsrIdxW = 1;

   localparam logic [CsrIdxW-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LOW  = 1'b1;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1b;

   typedef struct packed {
      logic [63:0] ct_high;
      logic [63:0] ct_low;
   } req_type;

   typedef struct packed {
      logic [63:0] pt_high;
      logic [63:0] pt_low;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_FIRST,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_block;
      logic exp_start;
      logic exp_step;
      logic first_add;
      logic round_step;
      logic last_round;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic exp_last;
      logic round_last;
   } sts_type;

   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
         8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
         8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
         8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
         8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
         8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
         8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
         8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
         8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
         8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
         8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
         8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
         8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
         8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
         8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
         8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sbox = t[x];
   endfunction

   function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      fwd_sbox = t[x];
   endfunction

   // inverse mix of one column, bytes a0..a3 msb first
   function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      for (int i = 0; i < 4; i++) begin
         a[i]  = col[31-8*i -: 8];
         x2[i] = xtime(a[i]);
         x4[i] = xtime(x2[i]);
         x8[i] = xtime(x4[i]);
         m9[i] = x8[i] ^ a[i];
         mb[i] = x8[i] ^ x2[i] ^ a[i];
         md[i] = x8[i] ^ x4[i] ^ a[i];
         me[i] = x8[i] ^ x4[i] ^ x2[i];
      end
      inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                     m9[0] ^ me[1] ^ mb[2] ^ md[3],
                     md[0] ^ m9[1] ^ me[2] ^ mb[3],
                     mb[0] ^ md[1] ^ m9[2] ^ me[3]};
   endfunction

endpackage

FILE: rtl/aesd_ctrl.sv
// controller: sequences key expansion and decryption rounds
module aesd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                csr_write,
   output aesd_pkg::cmd_type   cmd,
   input  aesd_pkg::sts_type   sts
);

   aesd_pkg::state_type state_ff, state_in;
   logic ready_ff, ready_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aesd_pkg::ST_IDLE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aesd_pkg::ST_IDLE: begin
            if (req_valid) state_in = ready_ff ? aesd_pkg::ST_FIRST : aesd_pkg::ST_EXPAND;
         end
         aesd_pkg::ST_EXPAND: begin
            if (sts.exp_last) state_in = aesd_pkg::ST_FIRST;
         end
         aesd_pkg::ST_FIRST: state_in = aesd_pkg::ST_ROUND;
         aesd_pkg::ST_ROUND: begin
            if (sts.round_last) state_in = aesd_pkg::ST_DONE;
         end
         aesd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = aesd_pkg::ST_IDLE;
         end
         default: state_in = aesd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         aesd_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.load_block = req_valid;
            cmd.exp_start  = req_valid && !ready_ff;
         end
         aesd_pkg::ST_EXPAND: begin
            cmd.exp_step = 1'b1;
            if (sts.exp_last) ready_in = 1'b1;
         end
         aesd_pkg::ST_FIRST: cmd.first_add = 1'b1;
         aesd_pkg::ST_ROUND: begin
            cmd.round_step = 1'b1;
            cmd.last_round = sts.round_last;
         end
         aesd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
      if (csr_write) ready_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_block |-> state_ff == aesd_pkg::ST_IDLE) else $error("load outside idle");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == aesd_pkg::ST_DONE) else $error("stray response");
   a_expand_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aesd_pkg::ST_EXPAND && sts.exp_last && !csr_write) |=> ready_ff)
      else $error("schedule not marked ready");

endmodule

FILE: rtl/aesd_datapath.sv
// datapath: key expansion unit, round key store and shared inverse round unit
module aesd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [aesd_pkg::CsrIdxW-1:0] csr_index,
   input  logic [aesd_pkg::KeyWordW-1:0] csr_data,
   input  aesd_pkg::req_type   req_data,
   output aesd_pkg::rsp_type   rsp_data,
   input  aesd_pkg::cmd_type   cmd,
   output aesd_pkg::sts_type   sts
);

   logic [63:0] key_high_ff, key_low_ff;
   logic [127:0] kexp_ff, kexp_in;
   logic [7:0] rcon_ff;
   logic [aesd_pkg::RoundW-1:0] kcnt_ff, rnd_ff;
   logic [127:0] state_ff, state_in;
   logic [127:0] rk_ff;
   aesd_pkg::rsp_type rsp_ff;
   logic [127:0] store [aesd_pkg::NumRounds+1];
   logic [aesd_pkg::RoundW-1:0] rd_addr;

   // key registers, all-zero key out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         if (csr_write && csr_index == aesd_pkg::CSR_KEY_HIGH) key_high_ff <= csr_data;
         if (csr_write && csr_index == aesd_pkg::CSR_KEY_LOW)  key_low_ff  <= csr_data;
      end
   end

   // next round key from the current one
   always_comb begin
      logic [31:0] w3, t;
      w3 = kexp_ff[31:0];
      t  = {aesd_pkg::fwd_sbox(w3[23:16]) ^ rcon_ff, aesd_pkg::fwd_sbox(w3[15:8]),
            aesd_pkg::fwd_sbox(w3[7:0]), aesd_pkg::fwd_sbox(w3[31:24])};
      kexp_in[127:96] = kexp_ff[127:96] ^ t;
      kexp_in[95:64]  = kexp_ff[95:64] ^ kexp_in[127:96];
      kexp_in[63:32]  = kexp_ff[63:32] ^ kexp_in[95:64];
      kexp_in[31:0]   = kexp_ff[31:0] ^ kexp_in[63:32];
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_start) begin
         kexp_ff <= {key_high_ff, key_low_ff};
         rcon_ff <= aesd_pkg::RCON_FIRST;
         kcnt_ff <= '0;
      end else if (cmd.exp_step) begin
         store[kcnt_ff] <= kexp_ff;
         kexp_ff <= kexp_in;
         rcon_ff <= aesd_pkg::xtime(rcon_ff);
         kcnt_ff <= kcnt_ff + 1'b1;
      end
   end

   assign sts.exp_last = kcnt_ff == aesd_pkg::RoundW'(aesd_pkg::NumRounds);

   // registered read of the round key store; outside the rounds the last
   // round key is kept ready for the next block
   always_comb begin
      if ((cmd.first_add || cmd.round_step) && !sts.round_last) rd_addr = rnd_ff - 1'b1;
      else rd_addr = aesd_pkg::RoundW'(aesd_pkg::NumRounds);
   end

   always_ff @(posedge clock) begin
      rk_ff <= (cmd.exp_step && sts.exp_last) ? kexp_ff : store[rd_addr];
   end

   // one inverse round per cycle
   always_comb begin
      logic [127:0] ss, mx;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            ss[127-8*(r+4*c) -: 8] =
               aesd_pkg::inv_sbox(state_ff[127-8*(r+4*((c-r+4)%4)) -: 8]);
      ss = ss ^ rk_ff;
      for (int c = 0; c < 4; c++)
         mx[127-32*c -: 32] = aesd_pkg::inv_mix_col(ss[127-32*c -: 32]);
      state_in = cmd.last_round ? ss : mx;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_block) begin
         state_ff <= {req_data.ct_high, req_data.ct_low};
         rnd_ff   <= aesd_pkg::RoundW'(aesd_pkg::NumRounds);
      end else if (cmd.first_add) begin
         state_ff <= state_ff ^ rk_ff;
         rnd_ff   <= rnd_ff - 1'b1;
      end else if (cmd.round_step) begin
         state_ff <= state_in;
         rnd_ff   <= rnd_ff - 1'b1;
      end
      if (cmd.rsp_load) rsp_ff <= {state_ff[127:64], state_ff[63:0]};
   end

   assign sts.round_last = rnd_ff == '0;
   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/aes128_block_decrypt.sv
// top level: AES-128 block decryptor with on-demand key expansion
// sequence: a block passes through the first key addition, the inverse rounds and the
// result register, after key expansion for the first block after reset or a key write
// acceptance: a new block is taken only in idle, after the previous result has been
// loaded for output, since all blocks share the single round unit
// reset: synchronous, active high; clears control, zeroes the key and marks the schedule stale
module aes128_block_decrypt (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  aesd_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output aesd_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic [aesd_pkg::CsrIdxW-1:0] csr_index,
   input  logic [aesd_pkg::KeyWordW-1:0] csr_data
);

   // command and status between controller and datapath
   aesd_pkg::cmd_type cmd;
   aesd_pkg::sts_type sts;

   aesd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .csr_write, .cmd, .sts);

   aesd_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_data, .rsp_data, .cmd, .sts);

endmodule
